[rtl/lrh_pkg.sv]
// Package for the linear RGB to HSV converter: payload structs, flags,
// and fixed constants of the sRGB linear segment. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lrh_pkg;

    typedef struct packed {
        logic [15:0] red_linear;
        logic [15:0] green_linear;
        logic [15:0] blue_linear;
    } lrh_pixel_t;

    typedef struct packed {
        logic [14:0] hue_deg;
        logic [15:0] saturation;
        logic [15:0] brightness;
    } lrh_result_t;

    typedef enum logic [1:0] {
        MAX_RED,
        MAX_GREEN,
        MAX_BLUE
    } lrh_max_t;

    typedef struct packed {
        logic dark;
        logic zero_sat;
        logic grey;
    } lrh_flags_t;

    // Stage load enables of the gamma pipe
    typedef struct packed {
        logic ld2;
        logic ld3;
        logic ld4;
    } lrh_gamma_en_t;

    // Linear segment: (x*1292 + 50) / 100, the /100 done by reciprocal
    localparam int          LIN_BITS     = 27;
    localparam logic [10:0] SRGB_SLOPE   = 11'd1292;
    localparam logic [6:0]  SRGB_ROUND   = 7'd50;
    localparam logic [27:0] DIV100_MUL   = 28'd171798692;
    localparam int          DIV100_SHIFT = 34;
    localparam int          DIV100_PBITS = 55;

endpackage

`default_nettype wire

[rtl/lrh_gamma.sv]
// sRGB linear-to-gamma curve for one channel: power-curve ROM with
// interpolation and the linear segment near black. Depends on lrh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lrh_gamma #(
    parameter int CHANNEL_BITS   = 16,
    parameter int GAMMA_ROM_BITS = 10
) (
    input  wire logic                      clk,
    input  wire lrh_pkg::lrh_gamma_en_t    en,
    input  wire logic [CHANNEL_BITS-1:0]   x,
    output logic      [CHANNEL_BITS-1:0]   gamma
);
    import lrh_pkg::*;

    localparam int CB       = CHANNEL_BITS;
    localparam int IB       = (GAMMA_ROM_BITS < CHANNEL_BITS) ? GAMMA_ROM_BITS : CHANNEL_BITS;
    localparam int SB       = CB - IB;
    localparam int ROM_SIZE = (2 ** IB) + 1;
    localparam int FW       = (SB > 0) ? SB : 1;
    localparam int PW       = CB + FW;
    localparam logic [63:0] FS     = (64'd1 << CB) - 64'd1;
    localparam logic [63:0] Q31    = 64'd1 << 31;
    localparam logic [63:0] KNEE64 = (FS * 64'd31308 + 64'd5000000) / 64'd10000000;
    localparam logic [CB-1:0] KNEE = CB'(KNEE64);
    localparam logic [PW-1:0] HALF = PW'((2 ** SB) / 2);

    typedef logic [CB-1:0] rom_t [ROM_SIZE];

    function automatic logic [63:0] q31_mul(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] p;
        p = a * b;
        return p >> 31;
    endfunction

    function automatic logic [63:0] pow12(input logic [63:0] z);
        logic [63:0] z2;
        logic [63:0] z4;
        logic [63:0] z8;
        z2 = q31_mul(z, z);
        z4 = q31_mul(z2, z2);
        z8 = q31_mul(z4, z4);
        return q31_mul(z8, z4);
    endfunction

    function automatic logic [63:0] power_entry(input logic [63:0] u);
        logic [63:0] a;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] z2;
        logic [63:0] y;
        logic [63:0] t;
        logic [63:0] v;
        logic [63:0] g;
        a  = (u << 31) / FS;
        lo = 64'd0;
        hi = Q31;
        for (int it = 0; it < 40; it++) begin
            if (lo < hi) begin
                mid = lo + ((hi - lo + 64'd1) >> 1);
                if (pow12(mid) <= a) lo = mid;
                else hi = mid - 64'd1;
            end
        end
        z2 = q31_mul(lo, lo);
        y  = q31_mul(q31_mul(z2, z2), lo);
        t  = 64'd1055 * y;
        if (t <= 64'd55 * Q31) return 64'd0;
        v = (t - 64'd55 * Q31 + 64'd500) / 64'd1000;
        g = (v * FS + (Q31 >> 1)) >> 31;
        if (g > FS) g = FS;
        return g;
    endfunction

    function automatic rom_t build_rom();
        rom_t        r;
        logic [63:0] u;
        for (int k = 0; k < ROM_SIZE; k++) begin
            u = 64'(k) << SB;
            if (u > FS) u = FS;
            r[k] = CB'(power_entry(u));
        end
        return r;
    endfunction

    localparam rom_t GAMMA_ROM = build_rom();

    logic [IB:0]       idx;
    logic [IB:0]       idx_hi;
    logic [FW-1:0]     frac;
    logic [LIN_BITS-1:0] lin_v;

    assign idx    = {1'b0, x[CB-1:SB]};
    assign idx_hi = idx + 1'b1;
    assign lin_v  = LIN_BITS'(x) * LIN_BITS'(SRGB_SLOPE) + LIN_BITS'(SRGB_ROUND);

    generate
        if (SB > 0) begin : g_frac
            assign frac = x[FW-1:0];
        end else begin : g_nofrac
            assign frac = '0;
        end
    endgenerate

    // Stage 2: ROM read, linear-segment product
    logic [CB-1:0]       lo2_reg;
    logic [CB-1:0]       hi2_reg;
    logic [FW-1:0]       frac2_reg;
    logic                knee2_reg;
    logic [LIN_BITS-1:0] linv2_reg;

    always_ff @(posedge clk)
    begin
        if (en.ld2)
        begin
            lo2_reg   <= GAMMA_ROM[idx];
            hi2_reg   <= GAMMA_ROM[idx_hi];
            frac2_reg <= frac;
            knee2_reg <= (x <= KNEE);
            linv2_reg <= lin_v;
        end
    end

    // Stage 3: interpolation product, reciprocal multiply for /100
    logic [CB-1:0]           diff;
    logic [DIV100_PBITS-1:0] lin_prod;
    logic [PW-1:0]           prod3_reg;
    logic [CB-1:0]           lo3_reg;
    logic [CB-1:0]           lin3_reg;
    logic                    knee3_reg;

    assign diff     = (hi2_reg >= lo2_reg) ? (hi2_reg - lo2_reg) : '0;
    assign lin_prod = DIV100_PBITS'(linv2_reg) * DIV100_PBITS'(DIV100_MUL);

    always_ff @(posedge clk)
    begin
        if (en.ld3)
        begin
            prod3_reg <= PW'(diff) * PW'(frac2_reg);
            lo3_reg   <= lo2_reg;
            lin3_reg  <= CB'(lin_prod >> DIV100_SHIFT);
            knee3_reg <= knee2_reg;
        end
    end

    // Stage 4: round and add
    logic [PW-1:0] step;
    logic [CB-1:0] gamma_reg;

    assign step = (prod3_reg + HALF) >> SB;

    always_ff @(posedge clk)
    begin
        if (en.ld4)
        begin
            gamma_reg <= knee3_reg ? lin3_reg : (lo3_reg + CB'(step));
        end
    end

    assign gamma = gamma_reg;

endmodule

`default_nettype wire

[rtl/lrh_div.sv]
// Pipelined restoring divider with side data and per-stage handshake.
// Quotient must fit QUO_BITS. Depends on no other file.
`timescale 1ns / 1ps
`default_nettype none

module lrh_div #(
    parameter int NUM_BITS  = 32,
    parameter int DEN_BITS  = 16,
    parameter int QUO_BITS  = 16,
    parameter int SIDE_BITS = 8,
    parameter int STEP_BITS = 2
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [NUM_BITS-1:0]  num,
    input  wire logic [DEN_BITS-1:0]  den,
    input  wire logic [SIDE_BITS-1:0] side,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [QUO_BITS-1:0]       quo,
    output logic [SIDE_BITS-1:0]      side_out
);
    localparam int STAGES = (QUO_BITS + STEP_BITS - 1) / STEP_BITS;

    logic                 vld_reg  [STAGES+1];
    logic [DEN_BITS-1:0]  rem_reg  [STAGES+1];
    logic [QUO_BITS-1:0]  work_reg [STAGES+1];
    logic [DEN_BITS-1:0]  den_reg  [STAGES+1];
    logic [SIDE_BITS-1:0] side_reg [STAGES+1];
    logic [STAGES+1:0]    en;

    assign en[STAGES+1] = out_ready;

    genvar k;
    generate
        for (k = 0; k <= STAGES; k++) begin : g_en
            assign en[k] = !vld_reg[k] || en[k+1];
        end
    endgenerate

    // Stage 0: remainder starts as the bits above the quotient
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en[0])
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rem_reg[0]  <= DEN_BITS'(num >> QUO_BITS);
            work_reg[0] <= num[QUO_BITS-1:0];
            den_reg[0]  <= den;
            side_reg[0] <= side;
        end
    end

    generate
        for (k = 1; k <= STAGES; k++) begin : g_stage
            logic [DEN_BITS:0]   r2;
            logic [DEN_BITS-1:0] rem_c;
            logic [QUO_BITS-1:0] work_c;
            logic                qbit;

            always_comb
            begin
                rem_c  = rem_reg[k-1];
                work_c = work_reg[k-1];
                r2     = '0;
                qbit   = 1'b0;
                for (int j = 0; j < STEP_BITS; j++) begin
                    if ((k - 1) * STEP_BITS + j < QUO_BITS)
                    begin
                        r2 = {rem_c, work_c[QUO_BITS-1]};
                        if (r2 >= {1'b0, den_reg[k-1]})
                        begin
                            r2   = r2 - {1'b0, den_reg[k-1]};
                            qbit = 1'b1;
                        end
                        else
                        begin
                            qbit = 1'b0;
                        end
                        rem_c  = r2[DEN_BITS-1:0];
                        work_c = {work_c[QUO_BITS-2:0], qbit};
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    rem_reg[k]  <= rem_c;
                    work_reg[k] <= work_c;
                    den_reg[k]  <= den_reg[k-1];
                    side_reg[k] <= side_reg[k-1];
                end
            end
        end
    endgenerate

    assign in_ready  = en[0];
    assign out_valid = vld_reg[STAGES];
    assign quo       = work_reg[STAGES];
    assign side_out  = side_reg[STAGES];

endmodule

`default_nettype wire

[rtl/linear_rgb_to_hsv.sv]
// Top level of the linear RGB to HSV converter: input stage, three gamma
// pipes, max/min and numerators, two pipelined dividers, output register.
// Depends on lrh_pkg, lrh_gamma, lrh_div.
//
//   channel | signals                      | moves
//   --------+------------------------------+-----------------------------
//   in      | in_valid in_ready in_pixel   | one linear RGB item
//   out     | out_valid out_ready out_result | one HSV item
//   cfg     | cfg_we cfg_data              | dark_threshold, no wait
//
// One item per clock sustained while out_ready stays high. The two divider
// pipes are radix-4, with S = ceil(CHANNEL_BITS/2) and H = ceil((HUE_FRAC_BITS+9)/2)
// divider stages for saturation and hue.
// Reset clears valid bits and sets dark_threshold to 1. Every stage has its
// own valid bit; a stalled output holds only the stages behind a full one.

`timescale 1ns / 1ps
`default_nettype none

module linear_rgb_to_hsv #(
    parameter int CHANNEL_BITS   = 16,
    parameter int GAMMA_ROM_BITS = 10,
    parameter int HUE_FRAC_BITS  = 6
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire lrh_pkg::lrh_pixel_t  in_pixel,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output lrh_pkg::lrh_result_t      out_result,
    input  wire logic                 cfg_we,
    input  wire logic [15:0]          cfg_data
);
    import lrh_pkg::*;

    localparam int CB        = CHANNEL_BITS;
    localparam int HF        = HUE_FRAC_BITS;
    localparam int QW        = HF + 9;
    localparam int HNW       = CB + HF + 10;
    localparam int HNW2      = HNW + 2;
    localparam int HDW       = CB + 1;
    localparam int SNW       = 2 * CB;
    localparam int TW        = (CB > 16) ? CB : 16;
    localparam int HUE_STEP  = 60 * (2 ** HF);
    localparam int SIDE1     = HNW + HDW + 3 + CB;
    localparam int SIDE2     = CB + 3 + CB;
    localparam logic [QW-1:0] HUE_WRAP = QW'(360 * (2 ** HF));
    localparam logic signed [HNW2-1:0] HS   = HNW2'(HUE_STEP);
    localparam logic signed [HNW2-1:0] K_R  = HNW2'(6 * HUE_STEP);
    localparam logic signed [HNW2-1:0] K_G  = HNW2'(2 * HUE_STEP);
    localparam logic signed [HNW2-1:0] K_B  = HNW2'(4 * HUE_STEP);

    logic [15:0] dark_threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dark_threshold_reg <= 16'd1;
        end
        else if (cfg_we)
        begin
            dark_threshold_reg <= cfg_data;
        end
    end

    // Front stages 1..7, ready chain back from the saturation divider
    logic [7:1] v_reg;
    logic [8:1] en_f;
    logic       sat_in_ready;

    assign en_f[8] = sat_in_ready;

    genvar s;
    generate
        for (s = 1; s <= 7; s++) begin : g_front_en
            assign en_f[s] = !v_reg[s] || en_f[s+1];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en_f[1])
            begin
                v_reg[1] <= in_valid;
            end
            for (int i = 2; i <= 7; i++) begin
                if (en_f[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    assign in_ready = en_f[1];

    // Stage 1: take the item
    logic [CB-1:0] r1_reg;
    logic [CB-1:0] g1_reg;
    logic [CB-1:0] b1_reg;

    always_ff @(posedge clk)
    begin
        if (en_f[1])
        begin
            r1_reg <= CB'(in_pixel.red_linear);
            g1_reg <= CB'(in_pixel.green_linear);
            b1_reg <= CB'(in_pixel.blue_linear);
        end
    end

    // Stages 2..4: gamma curve
    lrh_gamma_en_t gen;
    logic [CB-1:0] r4;
    logic [CB-1:0] g4;
    logic [CB-1:0] b4;

    assign gen.ld2 = en_f[2];
    assign gen.ld3 = en_f[3];
    assign gen.ld4 = en_f[4];

    lrh_gamma #(.CHANNEL_BITS(CB), .GAMMA_ROM_BITS(GAMMA_ROM_BITS)) u_gamma_r (
        .clk(clk), .en(gen), .x(r1_reg), .gamma(r4)
    );
    lrh_gamma #(.CHANNEL_BITS(CB), .GAMMA_ROM_BITS(GAMMA_ROM_BITS)) u_gamma_g (
        .clk(clk), .en(gen), .x(g1_reg), .gamma(g4)
    );
    lrh_gamma #(.CHANNEL_BITS(CB), .GAMMA_ROM_BITS(GAMMA_ROM_BITS)) u_gamma_b (
        .clk(clk), .en(gen), .x(b1_reg), .gamma(b4)
    );

    // Stage 5: max, min, which channel wins (ties favor red, then green)
    lrh_max_t         sel;
    logic [CB-1:0]    mx;
    logic [CB-1:0]    mn;
    logic signed [CB:0] sdiff;

    always_comb
    begin
        if (r4 >= g4 && r4 >= b4) sel = MAX_RED;
        else if (g4 >= b4) sel = MAX_GREEN;
        else sel = MAX_BLUE;

        mn = r4;
        if (g4 < mn) mn = g4;
        if (b4 < mn) mn = b4;

        case (sel)
            MAX_RED:
            begin
                mx    = r4;
                sdiff = $signed({1'b0, g4}) - $signed({1'b0, b4});
            end
            MAX_GREEN:
            begin
                mx    = g4;
                sdiff = $signed({1'b0, b4}) - $signed({1'b0, r4});
            end
            default:
            begin
                mx    = b4;
                sdiff = $signed({1'b0, r4}) - $signed({1'b0, g4});
            end
        endcase
    end

    lrh_max_t           sel5_reg;
    logic [CB-1:0]      mx5_reg;
    logic [CB-1:0]      mn5_reg;
    logic signed [CB:0] sdiff5_reg;

    always_ff @(posedge clk)
    begin
        if (en_f[5])
        begin
            sel5_reg   <= sel;
            mx5_reg    <= mx;
            mn5_reg    <= mn;
            sdiff5_reg <= sdiff;
        end
    end

    // Stage 6: delta and dark test
    lrh_max_t           sel6_reg;
    logic [CB-1:0]      mx6_reg;
    logic [CB-1:0]      delta6_reg;
    logic signed [CB:0] sdiff6_reg;
    logic               dark6_reg;
    logic               zero6_reg;

    always_ff @(posedge clk)
    begin
        if (en_f[6])
        begin
            sel6_reg   <= sel5_reg;
            mx6_reg    <= mx5_reg;
            delta6_reg <= mx5_reg - mn5_reg;
            sdiff6_reg <= sdiff5_reg;
            dark6_reg  <= (TW'(mx5_reg) < TW'(dark_threshold_reg));
            zero6_reg  <= (mx5_reg == '0);
        end
    end

    // Stage 7: divider operands
    logic signed [HNW2-1:0] sd_ext;
    logic signed [HNW2-1:0] dl_ext;
    logic signed [HNW2-1:0] k_term;
    logic signed [HNW2-1:0] hn;
    logic                   grey6;

    assign sd_ext = HNW2'(sdiff6_reg);
    assign dl_ext = $signed(HNW2'(delta6_reg));
    assign grey6  = (delta6_reg == '0);

    // Multiply by each sector offset constant, then pick
    always_comb
    begin
        case (sel6_reg)
            MAX_RED:   k_term = K_R * dl_ext;
            MAX_GREEN: k_term = K_G * dl_ext;
            default:   k_term = K_B * dl_ext;
        endcase
        hn = HS * sd_ext + k_term;
    end

    logic [SNW-1:0] sat_num7_reg;
    logic [CB-1:0]  sat_den7_reg;
    logic [HNW-1:0] hue_num7_reg;
    logic [HDW-1:0] hue_den7_reg;
    lrh_flags_t     flags7_reg;
    logic [CB-1:0]  mx7_reg;

    always_ff @(posedge clk)
    begin
        if (en_f[7])
        begin
            sat_num7_reg <= {delta6_reg, {CB{1'b0}}} - SNW'(delta6_reg) + SNW'(mx6_reg >> 1);
            sat_den7_reg <= zero6_reg ? CB'(1) : mx6_reg;
            hue_num7_reg <= HNW'((hn <<< 1) + dl_ext);
            hue_den7_reg <= grey6 ? HDW'(1) : {delta6_reg, 1'b0};
            flags7_reg.dark     <= dark6_reg;
            flags7_reg.zero_sat <= zero6_reg;
            flags7_reg.grey     <= grey6;
            mx7_reg      <= mx6_reg;
        end
    end

    // Saturation divider, hue operands ride along
    logic [SIDE1-1:0] side1_in;
    logic [SIDE1-1:0] side1_out;
    logic             sat_out_valid;
    logic             sat_out_ready;
    logic [CB-1:0]    sat_q;

    assign side1_in = {hue_num7_reg, hue_den7_reg, flags7_reg, mx7_reg};

    lrh_div #(
        .NUM_BITS(SNW), .DEN_BITS(CB), .QUO_BITS(CB), .SIDE_BITS(SIDE1), .STEP_BITS(2)
    ) u_sat_div (
        .clk(clk), .rst_n(rst_n),
        .in_valid(v_reg[7]), .in_ready(sat_in_ready),
        .num(sat_num7_reg), .den(sat_den7_reg), .side(side1_in),
        .out_valid(sat_out_valid), .out_ready(sat_out_ready),
        .quo(sat_q), .side_out(side1_out)
    );

    logic [HNW-1:0] hue_num8;
    logic [HDW-1:0] hue_den8;
    lrh_flags_t     flags8;
    logic [CB-1:0]  mx8;

    assign {hue_num8, hue_den8, flags8, mx8} = side1_out;

    // Hue divider, saturation rides along
    logic [SIDE2-1:0] side2_in;
    logic [SIDE2-1:0] side2_out;
    logic             hue_out_valid;
    logic             hue_out_ready;
    logic [QW-1:0]    hue_q;
    logic [CB-1:0]    sat9;
    lrh_flags_t       flags9;
    logic [CB-1:0]    mx9;

    assign side2_in = {sat_q, flags8, mx8};

    lrh_div #(
        .NUM_BITS(HNW), .DEN_BITS(HDW), .QUO_BITS(QW), .SIDE_BITS(SIDE2), .STEP_BITS(2)
    ) u_hue_div (
        .clk(clk), .rst_n(rst_n),
        .in_valid(sat_out_valid), .in_ready(sat_out_ready),
        .num(hue_num8), .den(hue_den8), .side(side2_in),
        .out_valid(hue_out_valid), .out_ready(hue_out_ready),
        .quo(hue_q), .side_out(side2_out)
    );

    assign {sat9, flags9, mx9} = side2_out;

    // Output register: wrap hue, zero the special cases
    logic          en_o;
    logic [QW-1:0] hue_w;
    logic          out_valid_reg;
    lrh_result_t   out_result_reg;

    assign en_o          = !out_valid_reg || out_ready;
    assign hue_out_ready = en_o;
    assign hue_w         = (hue_q >= HUE_WRAP) ? (hue_q - HUE_WRAP) : hue_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en_o)
        begin
            out_valid_reg <= hue_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_o)
        begin
            out_result_reg.hue_deg    <= (flags9.dark || flags9.grey) ? '0 : 15'(hue_w);
            out_result_reg.saturation <= (flags9.dark || flags9.zero_sat) ? '0 : 16'(sat9);
            out_result_reg.brightness <= flags9.dark ? '0 : 16'(mx9);
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

endmodule

`default_nettype wire

[dv/hsv_checker.sv]
// Checker for linear_rgb_to_hsv: watches the pixel, result and config ports,
// predicts each HSV item from the sRGB curve and compares in order.
// Depends on lrh_pkg.
`timescale 1ns / 1ps

module hsv_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  lrh_pkg::lrh_pixel_t  in_pixel,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  lrh_pkg::lrh_result_t out_result,
    input  logic                 cfg_we,
    input  logic [15:0]          cfg_data,
    output int                   fail_count,
    output int                   pending
);
    import lrh_pkg::*;

    localparam longint unsigned FS       = 65535;
    localparam longint unsigned Q31      = 64'd1 << 31;
    localparam longint unsigned KNEE_PT  = (FS * 31308 + 5000000) / 10000000;
    localparam int              SUB      = 6;
    localparam longint          HUE_UNIT = 60 << 6;
    localparam longint unsigned HUE_FULL = 360 << 6;

    longint unsigned power_rom [0:1024];
    logic [15:0]     dark_level;
    lrh_result_t     expected_hsv [$];

    function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
        return (a * b) >> 31;
    endfunction

    function automatic longint unsigned pow12(longint unsigned z);
        longint unsigned z2, z4, z8;
        z2 = qmul(z, z);
        z4 = qmul(z2, z2);
        z8 = qmul(z4, z4);
        return qmul(z8, z4);
    endfunction

    function automatic longint unsigned srgb_power(longint unsigned u);
        longint unsigned a, lo, hi, mid, z, z2, y, t, v, g;
        a  = (u << 31) / FS;
        lo = 0;
        hi = Q31;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            if (pow12(mid) <= a)
                lo = mid;
            else
                hi = mid - 1;
        end
        z  = lo;
        z2 = qmul(z, z);
        y  = qmul(qmul(z2, z2), z);
        t  = 1055 * y;
        if (t <= 55 * Q31)
            return 0;
        v = (t - 55 * Q31 + 500) / 1000;
        g = (v * FS + (Q31 >> 1)) >> 31;
        return (g > FS) ? FS : g;
    endfunction

    function automatic longint unsigned encode_gamma(logic [15:0] x);
        longint unsigned lo, hi, f;
        if (x <= KNEE_PT)
            return (longint'(x) * 1292 + 50) / 100;
        lo = power_rom[x >> SUB];
        hi = power_rom[(x >> SUB) + 1];
        f  = x & 16'h3f;
        if (hi < lo)
            hi = lo;
        return lo + (((hi - lo) * f + 32) >> SUB);
    endfunction

    function automatic lrh_result_t hsv_of_pixel(lrh_pixel_t p, logic [15:0] thr);
        longint unsigned r, g, b, mx, mn, delta, sat, hue;
        longint          n, d;
        lrh_result_t     res;
        r  = encode_gamma(p.red_linear);
        g  = encode_gamma(p.green_linear);
        b  = encode_gamma(p.blue_linear);
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        res = '0;
        if (mx < thr)
            return res;
        delta = mx - mn;
        sat   = 0;
        hue   = 0;
        if (mx != 0)
            sat = (delta * FS + mx / 2) / mx;
        if (delta != 0) begin
            d = delta;
            // ties go to red, then green
            if (r == mx)
                n = HUE_UNIT * (longint'(g) - longint'(b)) + 6 * HUE_UNIT * d;
            else if (g == mx)
                n = HUE_UNIT * (longint'(b) - longint'(r)) + 2 * HUE_UNIT * d;
            else
                n = HUE_UNIT * (longint'(r) - longint'(g)) + 4 * HUE_UNIT * d;
            hue = (2 * longint'(unsigned'(n)) + delta) / (2 * delta);
            if (hue >= HUE_FULL)
                hue -= HUE_FULL;
        end
        res.hue_deg    = hue[14:0];
        res.saturation = sat[15:0];
        res.brightness = mx[15:0];
        return res;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, field, got, want);
        fail_count++;
    endtask

    initial begin
        for (int k = 0; k <= 1024; k++)
            power_rom[k] = srgb_power((k << SUB) > FS ? FS : (k << SUB));
    end

    always @(posedge clk or negedge rst_n) begin
        lrh_result_t want;
        if (!rst_n) begin
            dark_level = 16'd1;
        end else begin
            if (in_valid && in_ready)
                expected_hsv.push_back(hsv_of_pixel(in_pixel, dark_level));
            if (out_valid && out_ready) begin
                if (expected_hsv.size() == 0) begin
                    $display("%0t: result item with nothing expected", $realtime);
                    fail_count++;
                end else begin
                    want = expected_hsv.pop_front();
                    if (out_result.hue_deg !== want.hue_deg)
                        report_mismatch("hue", out_result.hue_deg, want.hue_deg);
                    if (out_result.saturation !== want.saturation)
                        report_mismatch("saturation", out_result.saturation,
                                        want.saturation);
                    if (out_result.brightness !== want.brightness)
                        report_mismatch("brightness", out_result.brightness,
                                        want.brightness);
                end
            end
            if (cfg_we)
                dark_level = cfg_data;
        end
        pending = expected_hsv.size();
    end

endmodule

[dv/testbench.sv]
// Top of the linear_rgb_to_hsv testbench: clock, reset, pixel stimulus,
// output back-pressure, threshold writes and verdict. Depends on lrh_pkg,
// hsv_checker and the block itself.
`timescale 1ns / 1ps

module testbench;
    import lrh_pkg::*;

    localparam int DRAIN_CYCLES = 60;
    localparam int STALL_LIMIT  = 3000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    lrh_pixel_t  in_pixel = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    lrh_result_t out_result;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_data = '0;
    logic        ready_seen;
    logic        long_hold = 1'b0;
    logic        no_gaps = 1'b0;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;

    always #5 clk = ~clk;

    linear_rgb_to_hsv dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_pixel   (in_pixel),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_result (out_result),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data)
    );

    hsv_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_pixel   (in_pixel),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_result (out_result),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // sample ready away from the edge
    always @(negedge clk)
        ready_seen = in_ready;

    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(15);
        if (r < 10)
            return 0;
        if (r < 14)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    task automatic send_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_pixel <= '{red_linear: r, green_linear: g, blue_linear: b};
        do @(posedge clk); while (!ready_seen);
    endtask

    task automatic write_threshold(logic [15:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] rand_channel();
        case ($urandom_range(3))
            0: return 16'($urandom_range(400));
            1: return 16'($urandom_range(65535, 64000));
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    task automatic send_random(int count);
        logic [15:0] r, g, b;
        for (int k = 0; k < count; k++) begin
            r = rand_channel();
            g = rand_channel();
            b = rand_channel();
            // force ties and greys now and then
            case ($urandom_range(7))
                0: g = r;
                1: b = g;
                2: b = r;
                3: begin g = r; b = r; end
                default: ;
            endcase
            if (k % 200 == 0)
                no_gaps = ~no_gaps;
            send_pixel(r, g, b);
        end
    endtask

    // receiver: random stalls, free-running stretches, one long hold-off
    initial begin
        int r;
        @(posedge rst_n);
        forever begin
            if (long_hold) begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                long_hold = 1'b0;
            end else begin
                r = $urandom_range(15);
                if (r < 9) begin
                    out_ready <= 1'b1;
                    repeat ($urandom_range(8, 1)) @(posedge clk);
                end else if (r < 14) begin
                    out_ready <= 1'b0;
                    repeat ($urandom_range(3, 1)) @(posedge clk);
                end else if (r < 15) begin
                    out_ready <= 1'b0;
                    repeat ($urandom_range(40, 10)) @(posedge clk);
                end else begin
                    out_ready <= 1'b1;
                    repeat ($urandom_range(200, 50)) @(posedge clk);
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset threshold of 1: extremes, knee, ties, hue wrap
        send_pixel(16'd0, 16'd0, 16'd0);
        send_pixel(16'hffff, 16'hffff, 16'hffff);
        send_pixel(16'hffff, 16'd0, 16'd0);
        send_pixel(16'd0, 16'hffff, 16'd0);
        send_pixel(16'd0, 16'd0, 16'hffff);
        send_pixel(16'd205, 16'd206, 16'd204);
        send_pixel(16'd206, 16'd205, 16'd1);
        send_pixel(16'hffff, 16'hffff, 16'd0);
        send_pixel(16'd0, 16'hffff, 16'hffff);
        send_pixel(16'hffff, 16'd0, 16'hffff);
        send_pixel(16'hffff, 16'd1000, 16'd2000);
        send_pixel(16'd1, 16'd0, 16'd0);
        send_pixel(16'd30000, 16'd30000, 16'd30000);
        send_pixel(16'h5555, 16'haaaa, 16'h0f0f);

        write_threshold(16'd0);
        send_pixel(16'd0, 16'd0, 16'd0);
        send_pixel(16'd0, 16'd0, 16'd1);
        send_random(300);

        write_threshold(16'hffff);
        send_pixel(16'hffff, 16'hffff, 16'hffff);
        send_pixel(16'hfffe, 16'd0, 16'd0);
        send_random(150);

        write_threshold(16'd20000);
        long_hold = 1'b1;
        send_random(500);

        write_threshold(16'($urandom_range(65535)));
        send_random(300);

        write_threshold(16'd1);
        send_random(500);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
